// ===== design/linked_deque_manager_defines.svh =====
// Assertion helpers for the deque manager.
`ifndef LINKED_DEQUE_MANAGER_DEFINES_SVH
`define LINKED_DEQUE_MANAGER_DEFINES_SVH

// Clocked check, held off while reset is asserted.
`define LDM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check without a reset guard.
`define LDM_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/ldm_pkg.sv =====
package ldm_pkg;

	localparam int NUM_NODES = 1024;
	localparam int NUM_LISTS = 16;
	localparam int VALUE_W   = 32;
	localparam int LIST_ID_W = 4;

	localparam int NODE_IW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
	localparam int BUMP_W  = $clog2(NUM_NODES + 1);
	localparam int LIST_IW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int LINK_W  = NODE_IW + 1;

	typedef struct packed {
		logic               valid;
		logic [NODE_IW-1:0] idx;
	} link_t;

	typedef enum logic [2:0] {
		REQ_PUSH_F = 3'd0,
		REQ_PUSH_B = 3'd1,
		REQ_POP_F  = 3'd2,
		REQ_POP_B  = 3'd3,
		REQ_FREE   = 3'd4,
		REQ_PEEK_H = 3'd5,
		REQ_PEEK_T = 3'd6,
		REQ_NOP    = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	// list_id wraps modulo NUM_LISTS; small constant table
	function automatic logic [LIST_IW-1:0] list_wrap(input logic [LIST_ID_W-1:0] id);
		logic [LIST_IW-1:0] r;
		r = '0;
		for (int i = 0; i < (1 << LIST_ID_W); i++) begin
			if (id == LIST_ID_W'(i)) r = LIST_IW'(i % NUM_LISTS);
		end
		return r;
	endfunction

endpackage

// ===== design/ldm_ram.sv =====
module ldm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== design/linked_deque_manager.sv =====
// Linked deque manager: sixteen double-ended lists of 32-bit words share a
// pool of 1024 nodes. Node links and words live in three single-port-write,
// registered-read memories; list heads/tails and the free-list head are flops.
// One request at a time, one response word per request. Memory reads are
// registered; a node's two link updates that hit the same memory are
// written in consecutive states. Peek reads in S_PEEKR; pop reads in S_POPR
// and frees the node in S_POPW; push writes in S_PUSH1, after S_ALLOC when
// the node comes from the free list, then S_PUSH2 when the list was not
// empty; free walks S_FREER, one node per cycle on the next-link memory.
// Empty or full cases go straight to S_DONE. No clearing pass: nodes come
// from the free list, else a bump counter, so unwritten entries go unread.
module linked_deque_manager (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic [2:0]                     req_type,
	input  logic [ldm_pkg::LIST_ID_W-1:0]  list_id,
	input  logic [ldm_pkg::VALUE_W-1:0]    value,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [ldm_pkg::VALUE_W-1:0]    value_out,
	output logic [1:0]                     status
);
	import ldm_pkg::*;

	`include "linked_deque_manager_defines.svh"

	typedef enum logic [3:0] {
		S_IDLE, S_ALLOC, S_PUSH1, S_PUSH2, S_POPR, S_POPW, S_FREER, S_PEEKR, S_DONE
	} state_t;

	state_t              state_q;
	req_t                req_q;
	logic [LIST_IW-1:0]  lst_q;
	logic [VALUE_W-1:0]  val_q;
	logic [NODE_IW-1:0]  n_q;
	link_t               nb_q;
	link_t               head_q [NUM_LISTS];
	link_t               tail_q [NUM_LISTS];
	link_t               free_head_q;
	logic [BUMP_W-1:0]   bump_q;
	logic [VALUE_W-1:0]  res_val_q;
	status_t             res_st_q;
	logic                rsp_valid_q;
	logic [VALUE_W-1:0]  value_out_q;
	status_t             status_q;

	// memory ports
	logic               nx_we, pv_we, vl_we;
	logic [NODE_IW-1:0] nx_wa, pv_wa, raddr;
	link_t              nx_wd, pv_wd, nx_rd, pv_rd;
	logic [VALUE_W-1:0] vl_rd;

	req_t               req_in;
	logic [LIST_IW-1:0] lst_in;
	logic               front_q;
	link_t              nb_pop;

	assign req_in  = req_t'(req_type);
	assign lst_in  = list_wrap(list_id);
	assign front_q = (req_q == REQ_PUSH_F) || (req_q == REQ_POP_F);
	assign nb_pop  = front_q ? nx_rd : pv_rd;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign value_out = value_out_q;
	assign status    = status_q;

	ldm_ram #(.WIDTH(LINK_W), .DEPTH(NUM_NODES)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(raddr), .rdata(nx_rd)
	);
	ldm_ram #(.WIDTH(LINK_W), .DEPTH(NUM_NODES)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(raddr), .rdata(pv_rd)
	);
	ldm_ram #(.WIDTH(VALUE_W), .DEPTH(NUM_NODES)) u_val (
		.clk(clk), .we(vl_we), .waddr(n_q), .wdata(val_q), .raddr(raddr), .rdata(vl_rd)
	);

	// memory write and read-address steering
	always_comb begin
		nx_we = 1'b0;
		pv_we = 1'b0;
		vl_we = 1'b0;
		nx_wa = n_q;
		pv_wa = n_q;
		nx_wd = '0;
		pv_wd = '0;
		raddr = nx_rd.idx;
		case (state_q)
			S_IDLE: begin
				case (req_in)
					REQ_PUSH_F, REQ_PUSH_B: raddr = free_head_q.idx;
					REQ_POP_B, REQ_PEEK_T:  raddr = tail_q[lst_in].idx;
					default:                raddr = head_q[lst_in].idx;
				endcase
			end
			S_PUSH1: begin
				vl_we = 1'b1;
				nx_we = 1'b1;
				pv_we = 1'b1;
				nx_wd = front_q ? head_q[lst_q] : '0;
				pv_wd = front_q ? '0 : tail_q[lst_q];
			end
			S_PUSH2: begin
				// old end node now links to the new one
				if (front_q) begin
					pv_we = 1'b1;
					pv_wa = nb_q.idx;
					pv_wd = '{valid: 1'b1, idx: n_q};
				end else begin
					nx_we = 1'b1;
					nx_wa = nb_q.idx;
					nx_wd = '{valid: 1'b1, idx: n_q};
				end
			end
			S_POPR: begin
				// new end node loses its outward link
				if (nb_pop.valid) begin
					if (front_q) begin
						pv_we = 1'b1;
						pv_wa = nb_pop.idx;
					end else begin
						nx_we = 1'b1;
						nx_wa = nb_pop.idx;
					end
				end
			end
			S_POPW, S_FREER: begin
				nx_we = 1'b1;
				nx_wd = free_head_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= REQ_NOP;
			lst_q       <= '0;
			val_q       <= '0;
			n_q         <= '0;
			nb_q        <= '0;
			free_head_q <= '0;
			bump_q      <= '0;
			res_val_q   <= '0;
			res_st_q    <= ST_OK;
			rsp_valid_q <= 1'b0;
			value_out_q <= '0;
			status_q    <= ST_OK;
			for (int i = 0; i < NUM_LISTS; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			// S_DONE sets or holds the response itself
			if (rsp_ready && (state_q != S_DONE)) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q     <= req_in;
						lst_q     <= lst_in;
						val_q     <= value;
						res_val_q <= '0;
						res_st_q  <= ST_OK;
						state_q   <= S_DONE;
						case (req_in)
							REQ_PUSH_F, REQ_PUSH_B: begin
								if (free_head_q.valid) begin
									n_q     <= free_head_q.idx;
									state_q <= S_ALLOC;
								end else if (bump_q < BUMP_W'(NUM_NODES)) begin
									n_q     <= bump_q[NODE_IW-1:0];
									bump_q  <= bump_q + 1'b1;
									state_q <= S_PUSH1;
								end else begin
									res_st_q <= ST_FULL;
								end
							end
							REQ_POP_F, REQ_PEEK_H, REQ_FREE: begin
								if (!head_q[lst_in].valid) begin
									if (req_in != REQ_FREE) res_st_q <= ST_EMPTY;
								end else begin
									n_q <= head_q[lst_in].idx;
									case (req_in)
										REQ_POP_F:  state_q <= S_POPR;
										REQ_PEEK_H: state_q <= S_PEEKR;
										default:    state_q <= S_FREER;
									endcase
								end
							end
							REQ_POP_B, REQ_PEEK_T: begin
								if (!tail_q[lst_in].valid) begin
									res_st_q <= ST_EMPTY;
								end else begin
									n_q     <= tail_q[lst_in].idx;
									state_q <= (req_in == REQ_POP_B) ? S_POPR : S_PEEKR;
								end
							end
							default: ;
						endcase
					end
				end
				S_ALLOC: begin
					free_head_q <= nx_rd;
					state_q     <= S_PUSH1;
				end
				S_PUSH1: begin
					if (front_q) begin
						nb_q         <= head_q[lst_q];
						head_q[lst_q] <= '{valid: 1'b1, idx: n_q};
						if (!tail_q[lst_q].valid) tail_q[lst_q] <= '{valid: 1'b1, idx: n_q};
						state_q <= head_q[lst_q].valid ? S_PUSH2 : S_DONE;
					end else begin
						nb_q         <= tail_q[lst_q];
						tail_q[lst_q] <= '{valid: 1'b1, idx: n_q};
						if (!head_q[lst_q].valid) head_q[lst_q] <= '{valid: 1'b1, idx: n_q};
						state_q <= tail_q[lst_q].valid ? S_PUSH2 : S_DONE;
					end
				end
				S_PUSH2: state_q <= S_DONE;
				S_POPR: begin
					res_val_q <= vl_rd;
					if (front_q) begin
						head_q[lst_q] <= nb_pop;
						if (!nb_pop.valid) tail_q[lst_q] <= '0;
					end else begin
						tail_q[lst_q] <= nb_pop;
						if (!nb_pop.valid) head_q[lst_q] <= '0;
					end
					state_q <= S_POPW;
				end
				S_POPW: begin
					free_head_q <= '{valid: 1'b1, idx: n_q};
					state_q     <= S_DONE;
				end
				S_FREER: begin
					// node goes onto the free list front; follow its next link
					free_head_q <= '{valid: 1'b1, idx: n_q};
					if (nx_rd.valid) begin
						n_q <= nx_rd.idx;
					end else begin
						head_q[lst_q] <= '0;
						tail_q[lst_q] <= '0;
						state_q       <= S_DONE;
					end
				end
				S_PEEKR: begin
					res_val_q <= vl_rd;
					state_q   <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						value_out_q <= res_val_q;
						status_q    <= res_st_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`LDM_ASSERT(a_bump_range, (bump_q <= BUMP_W'(NUM_NODES)), "bump counter past pool size")
	`LDM_ASSERT(a_status_code, (rsp_valid |-> (status != ST_RSVD)), "reserved status code")
	`LDM_ASSERT(a_free_from_bump, (free_head_q.valid |-> (BUMP_W'(free_head_q.idx) < bump_q)), "free node never handed out")

endmodule
